// ----- rtl/assert_macros.svh -----
// Assertion macros used by the ICMP receive classifier datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checks that a consequent follows whenever the antecedent holds.
`define ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> cons) else $error(msg);

`endif

// ----- rtl/icr_pkg.sv -----
// Types, codes and a helper function of the ICMP receive classifier.
package icr_pkg;

   localparam int REDIRECT_ENTRIES_DEFAULT = 8;

   localparam logic [7:0] ICMP_TYPE_ECHO_REPLY   = 8'd0;
   localparam logic [7:0] ICMP_TYPE_REDIRECT     = 8'd5;
   localparam logic [7:0] ICMP_TYPE_ECHO_REQUEST = 8'd8;
   localparam logic [7:0] ICMP_TYPE_TS_REQUEST   = 8'd13;
   localparam logic [7:0] ICMP_TYPE_TS_REPLY     = 8'd14;

   typedef enum logic [2:0] {
      VERDICT_BAD_CHECKSUM = 3'd0,
      VERDICT_ECHO_REPLY   = 3'd1,
      VERDICT_TS_REPLY     = 3'd2,
      VERDICT_REDIRECT     = 3'd3,
      VERDICT_ECHO_OK      = 3'd4,
      VERDICT_ECHO_BAD_SEQ = 3'd5,
      VERDICT_IGNORED      = 3'd6
   } verdict_type;

   typedef struct packed {
      logic take_word;
      logic load_result;
      logic scan_start;
      logic scan_run;
      logic commit;
   } icr_cmd_type;

   typedef struct packed {
      logic out_free;
      logic is_redirect;
      logic scan_hit;
      logic scan_end;
   } icr_stat_type;

   function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + {15'd0, s[16]};
   endfunction

endpackage

// ----- rtl/icr_ctrl.sv -----
// Controller state machine of the ICMP receive classifier.
module icr_ctrl
   import icr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic         req_tlast,
   input  icr_stat_type stat,
   output icr_cmd_type  cmd
);

   typedef enum logic [1:0] {
      S_RUN,
      S_EVAL,
      S_SCAN
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_RUN: begin
            cmd.take_word = req_tvalid;
            if (req_tvalid && req_tlast) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (stat.out_free) begin
               if (stat.is_redirect) begin
                  cmd.scan_start = 1'b1;
                  state_in       = S_SCAN;
               end else begin
                  cmd.load_result = 1'b1;
                  state_in        = S_RUN;
               end
            end
         end
         S_SCAN: begin
            cmd.scan_run = 1'b1;
            if (stat.scan_hit || stat.scan_end) begin
               cmd.commit = 1'b1;
               state_in   = S_RUN;
            end
         end
         default: begin
            state_in = S_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_RUN;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == S_RUN);

endmodule

// ----- rtl/icr_datapath.sv -----
// Datapath of the ICMP receive classifier: sums, verdict, destination table and result register.
`include "assert_macros.svh"

module icr_datapath
   import icr_pkg::*;
#(
   parameter int REDIRECT_ENTRIES = REDIRECT_ENTRIES_DEFAULT
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic [15:0]  req_tdata,
   input  logic         req_tlast,
   input  logic [0:0]   req_tuser,
   input  logic         csr_valid,
   input  logic         csr_ready,
   input  logic [15:0]  csr_data,
   input  icr_cmd_type  cmd,
   output icr_stat_type stat,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata
);

   localparam int AddrW = $clog2(REDIRECT_ENTRIES);
   localparam logic [AddrW-1:0] LastAddr = AddrW'(REDIRECT_ENTRIES - 1);

   localparam logic [3:0] POS_HEADER   = 4'd0;
   localparam logic [3:0] POS_CHECKSUM = 4'd1;
   localparam logic [3:0] POS_SUM_FROM = 4'd2;
   localparam logic [3:0] POS_SEQUENCE = 4'd3;
   localparam logic [3:0] POS_TEN_LAST = 4'd9;
   localparam logic [3:0] POS_DEST_HI  = 4'd12;
   localparam logic [3:0] POS_DEST_LO  = 4'd13;
   localparam logic [3:0] POS_MAX      = 4'd15;

   logic [15:0] expected_seq_ff;

   logic [3:0]  pos_ff, pos_in;
   logic [15:0] first_word_ff, first_word_in;
   logic [15:0] rcv_cksum_ff, rcv_cksum_in;
   logic [15:0] rcv_seq_ff, rcv_seq_in;
   logic [15:0] run_sum_ff, run_sum_in;
   logic [15:0] psum_ten_ff, psum_ten_in;
   logic [31:0] dest_ff, dest_in;
   logic [15:0] word;

   logic [7:0]  msg_type;
   logic [7:0]  msg_code;
   logic [15:0] total;
   logic        cksum_ok;
   verdict_type verdict;
   logic [15:0] reply;

   logic [31:0]           dest_mem [REDIRECT_ENTRIES];
   logic [REDIRECT_ENTRIES-1:0] valid_ff, valid_in;
   logic [AddrW-1:0]      next_slot_ff, next_slot_in;
   logic [AddrW-1:0]      scan_addr_ff;
   logic                  scan_issue_ff;
   logic                  rd_live_ff;
   logic [AddrW-1:0]      rd_idx_ff;
   logic [31:0]           rd_data_ff;
   logic                  rd_valid_ff;
   logic [31:0]           rd_entry;
   logic [AddrW-1:0]      wr_slot;

   logic        rsp_valid_ff;
   verdict_type rsp_verdict_ff;
   logic [15:0] rsp_reply_ff;
   logic [2:0]  rsp_slot_ff;
   logic [7:0]  rsp_type_ff;
   logic        load;

   always_comb begin
      word = req_tdata;
      if (req_tlast && req_tuser[0]) begin
         word = {req_tdata[15:8], 8'h00};
      end
      pos_in        = pos_ff;
      first_word_in = first_word_ff;
      rcv_cksum_in  = rcv_cksum_ff;
      rcv_seq_in    = rcv_seq_ff;
      run_sum_in    = run_sum_ff;
      psum_ten_in   = psum_ten_ff;
      dest_in       = dest_ff;
      if (cmd.take_word) begin
         case (pos_ff)
            POS_HEADER:   first_word_in = word;
            POS_CHECKSUM: rcv_cksum_in = word;
            POS_SEQUENCE: rcv_seq_in = word;
            POS_DEST_HI:  dest_in = {word, dest_ff[15:0]};
            POS_DEST_LO:  dest_in = {dest_ff[31:16], word};
            default: ;
         endcase
         if (pos_ff >= POS_SUM_FROM) begin
            run_sum_in = oc_add(run_sum_ff, word);
            if (pos_ff <= POS_TEN_LAST) begin
               psum_ten_in = oc_add(psum_ten_ff, word);
            end
         end
         if (pos_ff != POS_MAX) begin
            pos_in = pos_ff + 4'd1;
         end
      end
      if (cmd.load_result || cmd.commit) begin
         pos_in        = '0;
         first_word_in = '0;
         rcv_cksum_in  = '0;
         rcv_seq_in    = '0;
         run_sum_in    = '0;
         psum_ten_in   = '0;
         dest_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         first_word_ff <= '0;
         rcv_cksum_ff  <= '0;
         rcv_seq_ff    <= '0;
         run_sum_ff    <= '0;
         psum_ten_ff   <= '0;
         dest_ff       <= '0;
      end else begin
         pos_ff        <= pos_in;
         first_word_ff <= first_word_in;
         rcv_cksum_ff  <= rcv_cksum_in;
         rcv_seq_ff    <= rcv_seq_in;
         run_sum_ff    <= run_sum_in;
         psum_ten_ff   <= psum_ten_in;
         dest_ff       <= dest_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_seq_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         expected_seq_ff <= csr_data;
      end
   end

   assign msg_type = first_word_ff[15:8];
   assign msg_code = first_word_ff[7:0];
   assign total    = oc_add(run_sum_ff, first_word_ff);
   assign cksum_ok = ((~total) == rcv_cksum_ff);

   always_comb begin
      reply   = '0;
      verdict = VERDICT_IGNORED;
      if (!cksum_ok) begin
         verdict = VERDICT_BAD_CHECKSUM;
      end else begin
         unique case (msg_type)
            ICMP_TYPE_ECHO_REQUEST: begin
               verdict = VERDICT_ECHO_REPLY;
               reply   = ~oc_add(run_sum_ff, {8'h00, msg_code});
            end
            ICMP_TYPE_TS_REQUEST: begin
               verdict = VERDICT_TS_REPLY;
               reply   = ~oc_add(psum_ten_ff, {ICMP_TYPE_TS_REPLY, msg_code});
            end
            ICMP_TYPE_REDIRECT: begin
               verdict = VERDICT_REDIRECT;
            end
            ICMP_TYPE_ECHO_REPLY: begin
               verdict = (rcv_seq_ff == expected_seq_ff) ? VERDICT_ECHO_OK
                                                         : VERDICT_ECHO_BAD_SEQ;
            end
            default: begin
               verdict = VERDICT_IGNORED;
            end
         endcase
      end
   end

   // The table is scanned one entry per cycle; a read issued here is registered and compared from that register.
   always_ff @(posedge clock) begin
      if (cmd.scan_run && scan_issue_ff) begin
         rd_data_ff  <= dest_mem[scan_addr_ff];
         rd_valid_ff <= valid_ff[scan_addr_ff];
         rd_idx_ff   <= scan_addr_ff;
      end
      if (cmd.commit) begin
         dest_mem[wr_slot] <= dest_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_addr_ff  <= '0;
         scan_issue_ff <= 1'b0;
         rd_live_ff    <= 1'b0;
      end else if (cmd.scan_start) begin
         scan_addr_ff  <= '0;
         scan_issue_ff <= 1'b1;
         rd_live_ff    <= 1'b0;
      end else if (cmd.scan_run) begin
         rd_live_ff <= scan_issue_ff;
         if (scan_issue_ff) begin
            if (scan_addr_ff == LastAddr) begin
               scan_issue_ff <= 1'b0;
            end else begin
               scan_addr_ff <= scan_addr_ff + AddrW'(1);
            end
         end
      end
   end

   assign rd_entry      = rd_valid_ff ? rd_data_ff : '0;
   assign stat.scan_hit = rd_live_ff && (rd_entry == dest_ff);
   assign stat.scan_end = rd_live_ff && (rd_idx_ff == LastAddr);
   assign wr_slot       = stat.scan_hit ? rd_idx_ff : next_slot_ff;

   always_comb begin
      valid_in     = valid_ff;
      next_slot_in = next_slot_ff;
      if (cmd.commit) begin
         valid_in[wr_slot] = 1'b1;
         if (!stat.scan_hit) begin
            next_slot_in = (next_slot_ff == LastAddr) ? '0 : next_slot_ff + AddrW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         next_slot_ff <= '0;
      end else begin
         valid_ff     <= valid_in;
         next_slot_ff <= next_slot_in;
      end
   end

   assign stat.out_free    = !rsp_valid_ff || rsp_tready;
   assign stat.is_redirect = cksum_ok && (msg_type == ICMP_TYPE_REDIRECT);
   assign load             = cmd.load_result || cmd.commit;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_result) begin
         rsp_verdict_ff <= verdict;
         rsp_reply_ff   <= reply;
         rsp_slot_ff    <= '0;
         rsp_type_ff    <= msg_type;
      end else if (cmd.commit) begin
         rsp_verdict_ff <= VERDICT_REDIRECT;
         rsp_reply_ff   <= '0;
         rsp_slot_ff    <= 3'(wr_slot);
         rsp_type_ff    <= msg_type;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_type_ff, rsp_slot_ff, rsp_reply_ff, rsp_verdict_ff};

   `ASSERT_IMPLY(a_load_needs_room, load, (!rsp_valid_ff || rsp_tready), "load over full")
   `ASSERT_IMPLY(a_commit_marks_valid, cmd.commit, ##1 valid_ff[$past(wr_slot)], "no valid bit")
   `ASSERT_IMPLY(a_clear_after_result, load, ##1 (pos_ff == '0 && run_sum_ff == '0), "no clear")

endmodule

// ----- rtl/icmp_receive_classifier_core.sv -----
// Top level of the ICMP receive classifier.
//
//   Channel   Direction   Handshake               Content
//   req_*     in          req_tvalid/req_tready   one 16-bit message word
//   rsp_*     out         rsp_tvalid/rsp_tready   one verdict per message
//   csr_*     in          csr_valid/csr_ready     expected echo sequence
//
// Every word except the last is taken whenever it is valid in the run state.
// After the last word the controller gives the checksum verdict in its evaluation state and
// waits there while the result register still holds a word that has not been taken.
// A redirect scans the destination table one entry per cycle and stops at the first match
// or after the last entry.
// Reset is synchronous and clears the table at once through per-entry valid bits.
module icmp_receive_classifier_core
   import icr_pkg::*;
#(
   parameter int REDIRECT_ENTRIES = REDIRECT_ENTRIES_DEFAULT
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // data_word
   input  logic        req_tlast,
   input  logic [0:0]  req_tuser,   // odd_tail
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // verdict, reply_checksum, redirect_slot, message_type
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);

   icr_cmd_type  cmd;
   icr_stat_type stat;

   assign csr_ready = 1'b1;

   icr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tlast  (req_tlast),
      .stat       (stat),
      .cmd        (cmd)
   );

   icr_datapath #(
      .REDIRECT_ENTRIES (REDIRECT_ENTRIES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ----- dv/icr_checker.sv -----
// Checker that predicts and compares the verdict words of the ICMP receive classifier.
module icr_checker
   import icr_pkg::*;
#(
   parameter int REDIRECT_ENTRIES = REDIRECT_ENTRIES_DEFAULT
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,
   input  logic        req_tlast,
   input  logic [0:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [15:0] csr_data,
   output int          fail_count,
   output int          verdicts_due
);

   typedef struct {
      verdict_type verdict;
      logic [15:0] reply_sum;
      logic [2:0]  slot;
      logic [7:0]  msg_type;
   } verdict_word_type;

   logic [15:0] echo_seq;
   logic [15:0] sum_all;
   logic [15:0] sum_ten;
   logic [15:0] type_word;
   logic [15:0] csum_field;
   logic [15:0] seq_field;
   logic [3:0]  word_index;
   logic [31:0] gateway;
   logic [31:0] inner_dest;
   logic [31:0] dest_tab [REDIRECT_ENTRIES];
   logic [31:0] gw_tab [REDIRECT_ENTRIES];
   int          fill_slot;
   verdict_word_type verdicts_q [$];

   function automatic logic [15:0] fold_add(input logic [15:0] a, input logic [15:0] b);
      logic [31:0] t;
      t = 32'(a) + 32'(b);
      t = t[15:0] + t[31:16];
      return t[15:0];
   endfunction

   task automatic clear_message();
      sum_all = '0;
      sum_ten = '0;
      type_word = '0;
      csum_field = '0;
      seq_field = '0;
      word_index = '0;
      gateway = '0;
      inner_dest = '0;
   endtask

   task automatic predict_word(input logic [15:0] data, input logic last, input logic odd);
      logic [15:0] w;
      logic [15:0] total;
      logic [7:0]  mtype;
      logic [7:0]  mcode;
      verdict_word_type r;
      bit hit;
      int i;
      w = (last && odd) ? {data[15:8], 8'h00} : data;
      case (word_index)
         4'd0: type_word = w;
         4'd1: csum_field = w;
         4'd2: gateway[31:16] = w;
         4'd3: begin
            gateway[15:0] = w;
            seq_field = w;
         end
         4'd12: inner_dest[31:16] = w;
         4'd13: inner_dest[15:0] = w;
         default: ;
      endcase
      if (word_index >= 4'd2) begin
         sum_all = fold_add(sum_all, w);
         if (word_index <= 4'd9) begin
            sum_ten = fold_add(sum_ten, w);
         end
      end
      if (word_index != 4'd15) begin
         word_index = word_index + 4'd1;
      end
      if (last) begin
         mtype = type_word[15:8];
         mcode = type_word[7:0];
         total = fold_add(sum_all, type_word);
         r.verdict = VERDICT_IGNORED;
         r.reply_sum = '0;
         r.slot = '0;
         r.msg_type = mtype;
         if (~total != csum_field) begin
            r.verdict = VERDICT_BAD_CHECKSUM;
         end else if (mtype == ICMP_TYPE_ECHO_REQUEST) begin
            r.verdict = VERDICT_ECHO_REPLY;
            r.reply_sum = ~fold_add(sum_all, {ICMP_TYPE_ECHO_REPLY, mcode});
         end else if (mtype == ICMP_TYPE_TS_REQUEST) begin
            r.verdict = VERDICT_TS_REPLY;
            r.reply_sum = ~fold_add(sum_ten, {ICMP_TYPE_TS_REPLY, mcode});
         end else if (mtype == ICMP_TYPE_REDIRECT) begin
            hit = 1'b0;
            for (i = 0; i < REDIRECT_ENTRIES; i++) begin
               if (!hit && dest_tab[i] == inner_dest) begin
                  gw_tab[i] = gateway;
                  r.slot = i[2:0];
                  hit = 1'b1;
               end
            end
            if (!hit) begin
               dest_tab[fill_slot] = inner_dest;
               gw_tab[fill_slot] = gateway;
               r.slot = fill_slot[2:0];
               fill_slot = (fill_slot + 1 == REDIRECT_ENTRIES) ? 0 : fill_slot + 1;
            end
            r.verdict = VERDICT_REDIRECT;
         end else if (mtype == ICMP_TYPE_ECHO_REPLY) begin
            r.verdict = (seq_field == echo_seq) ? VERDICT_ECHO_OK : VERDICT_ECHO_BAD_SEQ;
         end
         verdicts_q.push_back(r);
         clear_message();
      end
   endtask

   task automatic compare_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t: %s expected %h actual %h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      verdict_word_type due;
      if (reset) begin
         echo_seq = '0;
         clear_message();
         for (int i = 0; i < REDIRECT_ENTRIES; i++) begin
            dest_tab[i] = '0;
            gw_tab[i] = '0;
         end
         fill_slot = 0;
         verdicts_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            echo_seq = csr_data;
         end
         if (req_tvalid && req_tready) begin
            predict_word(req_tdata, req_tlast, req_tuser[0]);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (verdicts_q.size() == 0) begin
               fail_count++;
               $display("%0t: word with no verdict due, expected none actual %h",
                        $time, rsp_tdata);
            end else begin
               due = verdicts_q.pop_front();
               compare_field("verdict", 16'(due.verdict), 16'(rsp_tdata[2:0]));
               compare_field("reply checksum", due.reply_sum, rsp_tdata[18:3]);
               compare_field("redirect slot", 16'(due.slot), 16'(rsp_tdata[21:19]));
               compare_field("message type", 16'(due.msg_type), 16'(rsp_tdata[29:22]));
               compare_field("padding", 16'h0000, 16'(rsp_tdata[31:30]));
            end
         end
      end
      verdicts_due <= verdicts_q.size();
   end

endmodule

// ----- dv/testbench.sv -----
// Top of the ICMP receive classifier testbench: clock, reset, stimulus and final verdict.
module testbench
   import icr_pkg::*;
();

   localparam int TABLE_SIZE  = REDIRECT_ENTRIES_DEFAULT;
   localparam int WORD_TARGET = 1050;
   localparam int CYCLE_LIMIT = 300000;

   localparam int FILL_RANDOM = 0;
   localparam int FILL_ONES   = 1;
   localparam int FILL_ZEROS  = 2;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;
   logic        req_tlast;
   logic [0:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        csr_valid;
   logic        csr_ready;
   logic [15:0] csr_data;
   int          fail_count;
   int          verdicts_due;
   int          cycle_count = 0;
   int          words_sent = 0;
   bit          no_idle = 1'b0;
   bit          hold_request = 1'b0;
   logic [15:0] echo_seq_now = '0;
   logic [31:0] dest_pool [12];
   logic [15:0] msg_words [$];

   icmp_receive_classifier_core #(
      .REDIRECT_ENTRIES(TABLE_SIZE)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   icr_checker #(
      .REDIRECT_ENTRIES(TABLE_SIZE)
   ) u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tlast    (req_tlast),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_data     (csr_data),
      .fail_count   (fail_count),
      .verdicts_due (verdicts_due)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("icmp_receive_classifier_core test failed");
         $finish;
      end
   end

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 65) begin
         return 0;
      end
      if (r < 93) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   // The result side: random stalls, plus one long hold-off when asked for.
   initial begin
      int hold_left;
      int gap_left;
      bit hold_taken;
      hold_left = 0;
      gap_left = 0;
      hold_taken = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (gap_left > 0) begin
            gap_left--;
            rsp_tready <= 1'b0;
         end else begin
            gap_left = ($urandom_range(0, 3) == 0) ? idle_len() : 0;
            rsp_tready <= (gap_left == 0);
            if (gap_left > 0) begin
               gap_left--;
            end
         end
      end
   end

   task automatic send_word(input logic [15:0] data, input logic last, input logic odd);
      int gap;
      gap = idle_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= data;
      req_tlast <= last;
      req_tuser <= odd;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      words_sent++;
   endtask

   // Builds one message and sends it; the fill kind picks random content, all ones or all zeros.
   task automatic send_message(input logic [7:0] mtype, input int len, input bit odd_end,
                               input bit good, input int fill);
      logic [15:0] acc;
      logic [15:0] w;
      logic [16:0] t;
      logic [31:0] dest;
      int i;
      msg_words.delete();
      for (i = 0; i < len; i++) begin
         w = (fill == FILL_ONES) ? 16'hFFFF : (fill == FILL_ZEROS) ? 16'h0000 : 16'($urandom);
         msg_words.push_back(w);
      end
      msg_words[0] = {mtype, msg_words[0][7:0]};
      if (mtype == ICMP_TYPE_ECHO_REPLY && fill == FILL_RANDOM && len > 3
          && $urandom_range(0, 2) != 0) begin
         msg_words[3] = echo_seq_now;
      end
      if (mtype == ICMP_TYPE_REDIRECT && fill == FILL_RANDOM) begin
         dest = dest_pool[$urandom_range(0, 11)];
         if (len > 12) msg_words[12] = dest[31:16];
         if (len > 13) msg_words[13] = dest[15:0];
      end
      if (len > 1) begin
         acc = '0;
         for (i = 0; i < len; i++) begin
            if (i != 1) begin
               w = msg_words[i];
               if (i == len - 1 && odd_end) w[7:0] = 8'h00;
               t = {1'b0, acc} + {1'b0, w};
               acc = t[15:0] + 16'(t[16]);
            end
         end
         msg_words[1] = ~acc;
         if (!good) msg_words[1] = msg_words[1] ^ 16'($urandom_range(1, 65535));
      end
      for (i = 0; i < len; i++) begin
         if (i == len - 1) begin
            send_word(msg_words[i], 1'b1, odd_end);
         end else begin
            send_word(msg_words[i], 1'b0, $urandom_range(0, 4) == 0);
         end
      end
   endtask

   task automatic random_message();
      int pick;
      int len;
      logic [7:0] mtype;
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
         mtype = ICMP_TYPE_ECHO_REQUEST;
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(4, 16);
      end else if (pick < 40) begin
         mtype = ICMP_TYPE_TS_REQUEST;
         len = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 9) : $urandom_range(10, 18);
      end else if (pick < 62) begin
         mtype = ICMP_TYPE_REDIRECT;
         len = ($urandom_range(0, 5) == 0) ? $urandom_range(2, 13) : $urandom_range(14, 18);
      end else if (pick < 82) begin
         mtype = ICMP_TYPE_ECHO_REPLY;
         len = $urandom_range(2, 12);
      end else begin
         mtype = 8'($urandom);
         len = $urandom_range(1, 12);
      end
      send_message(mtype, len, $urandom_range(0, 9) == 0, $urandom_range(0, 7) != 0,
                   FILL_RANDOM);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (verdicts_due != 0) @(posedge clock);
   endtask

   task automatic write_echo_seq(input logic [15:0] value);
      wait_drained();
      repeat (TABLE_SIZE + 4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      echo_seq_now = value;
   endtask

   initial begin
      logic [15:0] seq_values [5];
      int phase;
      int base_words;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      req_tuser = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      dest_pool[0] = 32'h0000_0000;
      dest_pool[1] = 32'hFFFF_FFFF;
      for (int i = 2; i < 12; i++) begin
         dest_pool[i] = $urandom;
      end
      seq_values[0] = 16'hFFFF;
      seq_values[1] = 16'($urandom);
      seq_values[2] = 16'h0001;
      seq_values[3] = 16'($urandom);
      seq_values[4] = 16'h8000;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      write_echo_seq(16'h0000);

      send_message(ICMP_TYPE_ECHO_REQUEST, 4, 1'b0, 1'b1, FILL_ONES);
      send_message(ICMP_TYPE_ECHO_REQUEST, 4, 1'b0, 1'b1, FILL_ZEROS);
      send_message(ICMP_TYPE_TS_REQUEST, 10, 1'b0, 1'b1, FILL_RANDOM);
      send_message(ICMP_TYPE_TS_REQUEST, 5, 1'b0, 1'b1, FILL_RANDOM);
      send_message(ICMP_TYPE_REDIRECT, 14, 1'b0, 1'b1, FILL_ZEROS);
      send_message(ICMP_TYPE_REDIRECT, 14, 1'b0, 1'b1, FILL_ONES);
      send_message(ICMP_TYPE_ECHO_REPLY, 4, 1'b0, 1'b1, FILL_ZEROS);
      send_message(ICMP_TYPE_ECHO_REPLY, 4, 1'b0, 1'b1, FILL_ONES);
      send_message(ICMP_TYPE_ECHO_REQUEST, 6, 1'b0, 1'b0, FILL_RANDOM);
      send_message(8'hFF, 3, 1'b1, 1'b1, FILL_RANDOM);
      send_message(8'hFF, 1, 1'b0, 1'b1, FILL_ONES);
      send_message(ICMP_TYPE_ECHO_REPLY, 1, 1'b0, 1'b1, FILL_ZEROS);
      send_message(ICMP_TYPE_ECHO_REQUEST, 5, 1'b1, 1'b1, FILL_RANDOM);
      send_message(ICMP_TYPE_ECHO_REQUEST, 18, 1'b0, 1'b1, FILL_RANDOM);

      base_words = words_sent;
      for (phase = 0; phase < 5; phase++) begin
         write_echo_seq(seq_values[phase]);
         no_idle = (phase == 1);
         if (phase == 2) begin
            hold_request = 1'b1;
         end
         while (words_sent < base_words + (phase + 1) * (WORD_TARGET - base_words) / 5) begin
            if (phase == 3 && words_sent >= base_words + (7 * (WORD_TARGET - base_words)) / 10
                && words_sent < base_words + (7 * (WORD_TARGET - base_words)) / 10 + 8) begin
               wait_drained();
            end
            random_message();
         end
      end
      no_idle = 1'b0;

      wait_drained();
      repeat (TABLE_SIZE + 20) @(posedge clock);
      if (fail_count == 0) begin
         $display("icmp_receive_classifier_core test passed");
      end else begin
         $display("icmp_receive_classifier_core test failed");
      end
      $finish;
   end

endmodule
